// File: rtl/core/swd_pkg.sv
package swd_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int POS_W       = 5;
  localparam int CNTF_W      = 5;
  localparam int CMP_W       = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_PEEK   = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  typedef struct packed {
    logic [1:0]       func;
    logic [15:0]      plane_id;
    logic [63:0]      plane_tag;
    logic [POS_W-1:0] position;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [15:0]       out_id;
    logic [63:0]       out_tag;
    logic [CNTF_W-1:0] count_after;
  } out_word_t;

  typedef struct packed {
    logic [15:0] id;
    logic [63:0] tag;
  } entry_t;

  typedef struct packed {
    logic load_above;
    logic load_below;
  } cell_ctl_t;

endpackage

// File: rtl/core/swd_cell.sv
module swd_cell (
  input  logic               clk,
  input  swd_pkg::cell_ctl_t ctl,
  input  swd_pkg::entry_t    from_above,
  input  swd_pkg::entry_t    from_below,
  output swd_pkg::entry_t    q
);
  import swd_pkg::*;

  entry_t data_r;
  entry_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.load_above) begin
      data_nxt = from_above;
    end else if (ctl.load_below) begin
      data_nxt = from_below;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

// File: rtl/core/stack_with_remove_at_depth_top.sv
// Bounded LIFO stack of STACK_DEPTH entries (16-bit id, 64-bit tag) kept in a
// chain of cells, cell 0 holding the top. Push shifts every cell one place
// down, pop and remove-at-position shift the cells at and below the removed
// place one place up, all in the same edge: a request accepted at one edge
// shows its result word in the output register from the next cycle, and a
// new request is taken at every edge at which the output register is empty
// or its word is being taken. The sustained rate is one request per cycle
// while the output side takes every word. The removed entry of a
// remove-at-position is picked from the cell row by the position field.
// Entries never pushed read as undefined but are never returned.
module stack_with_remove_at_depth_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  swd_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output swd_pkg::out_word_t  out_data
);
  import swd_pkg::*;

  entry_t    cell_q   [STACK_DEPTH];
  cell_ctl_t cell_ctl [STACK_DEPTH];
  entry_t    push_entry;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  out_word_t        out_data_r;
  out_word_t        res;

  logic             accept;
  logic             is_full;
  logic             is_empty;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             pos_ok;
  logic             do_push;
  logic             do_pull;
  entry_t           pos_entry;

  assign in_ready   = !out_valid_r || out_ready;
  assign accept     = in_valid && in_ready;
  assign is_full    = (count_r == CNT_W'(STACK_DEPTH));
  assign is_empty   = (count_r == '0);
  assign pos_ext    = CMP_W'(in_data.position);
  assign cnt_ext    = CMP_W'(count_r);
  assign pos_ok     = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign push_entry = '{id: in_data.plane_id, tag: in_data.plane_tag};

  assign do_push = accept && (in_data.func == OP_PUSH) && !is_full;
  assign do_pull = accept && (((in_data.func == OP_POP) && !is_empty) ||
                              ((in_data.func == OP_REMOVE) && pos_ok));

  // Pick the entry at the requested place.
  always_comb begin
    pos_entry = '0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      if (pos_ext == CMP_W'(i + 1)) begin
        pos_entry = cell_q[i];
      end
    end
  end

  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    entry_t above;
    entry_t below;
    logic   at_or_below;

    if (g == 0) begin : g_top
      assign above = push_entry;
    end else begin : g_mid
      assign above = cell_q[g-1];
    end
    if (g == STACK_DEPTH - 1) begin : g_bot
      assign below = cell_q[g];
    end else begin : g_up
      assign below = cell_q[g+1];
    end

    // Pop acts as removal of the top place.
    assign at_or_below = (in_data.func == OP_POP) || (pos_ext <= CMP_W'(g + 1));
    assign cell_ctl[g].load_above = do_push;
    assign cell_ctl[g].load_below = do_pull && at_or_below;

    swd_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[g]),
      .from_above (above),
      .from_below (below),
      .q          (cell_q[g])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (do_push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pull) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    res        = '0;
    res.status = ST_OK;
    case (in_data.func)
      OP_PUSH: begin
        if (is_full) begin
          res.status = ST_FULL;
        end
      end
      OP_POP, OP_PEEK: begin
        if (is_empty) begin
          res.status = ST_EMPTY;
        end else begin
          res.out_id  = cell_q[0].id;
          res.out_tag = cell_q[0].tag;
        end
      end
      OP_REMOVE: begin
        if (!pos_ok) begin
          res.status = ST_BADPOS;
        end else begin
          res.out_id  = pos_entry.id;
          res.out_tag = pos_entry.tag;
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
    res.count_after = CNTF_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the result word until taken.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("entry count above stack depth");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_push |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("push did not raise the count");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(count_r))
    else $error("count changed with no request");

  a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_valid && out_data.count_after == CNTF_W'(count_r)))
    else $error("result count differs from held count");

endmodule

// File: tb/tb_stack_with_remove_at_depth_top.sv
`timescale 1ns / 1ps

module tb_stack_with_remove_at_depth_top;
  import swd_pkg::*;

  localparam int RANDOM_ITEMS = 1600;
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 300;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  stack_with_remove_at_depth_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // shadow copy of the stack, entry 0 at the bottom
  entry_t    shadow_stack [STACK_DEPTH];
  int        shadow_depth = 0;
  int        deepest = 0;

  in_word_t  pending_requests [$];
  out_word_t expected_results [$];

  int        send_gap = 0;
  int        recv_stall = 0;
  int        hold_left = 0;
  int        words_sent = 0;
  int        words_seen = 0;
  int        idle_cycles = 0;
  int        error_count = 0;
  int        op_count [4] = '{0, 0, 0, 0};
  int        status_count [4] = '{0, 0, 0, 0};

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic out_word_t apply_stack_op(in_word_t req);
    out_word_t res;
    int        k;
    int        i;
    res = '0;
    res.status = ST_OK;
    case (req.func)
      OP_PUSH: begin
        if (shadow_depth >= STACK_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_stack[shadow_depth].id  = req.plane_id;
          shadow_stack[shadow_depth].tag = req.plane_tag;
          shadow_depth++;
        end
      end
      OP_POP: begin
        if (shadow_depth == 0) begin
          res.status = ST_EMPTY;
        end else begin
          shadow_depth--;
          res.out_id  = shadow_stack[shadow_depth].id;
          res.out_tag = shadow_stack[shadow_depth].tag;
        end
      end
      OP_REMOVE: begin
        if (req.position == 0 || int'(req.position) > shadow_depth) begin
          res.status = ST_BADPOS;
        end else begin
          k = shadow_depth - int'(req.position);
          res.out_id  = shadow_stack[k].id;
          res.out_tag = shadow_stack[k].tag;
          // close the gap: entries above slide down one place
          for (i = k; i + 1 < shadow_depth; i++) begin
            shadow_stack[i] = shadow_stack[i + 1];
          end
          shadow_depth--;
        end
      end
      default: begin
        if (shadow_depth == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.out_id  = shadow_stack[shadow_depth - 1].id;
          res.out_tag = shadow_stack[shadow_depth - 1].tag;
        end
      end
    endcase
    if (shadow_depth > deepest) deepest = shadow_depth;
    res.count_after = shadow_depth[CNTF_W-1:0];
    return res;
  endfunction

  function automatic in_word_t make_request(logic [1:0] func, int pos);
    in_word_t w;
    w.func      = func;
    w.plane_id  = 16'($urandom);
    w.plane_tag = {$urandom, $urandom};
    w.position  = POS_W'(pos);
    return w;
  endfunction

  // bias 0 fills, bias 1 drains, anything else mixes evenly
  function automatic in_word_t make_random_request(int bias);
    logic [1:0] func;
    int         r;
    int         pos;
    r = $urandom_range(0, 99);
    case (bias)
      0:       func = (r < 60) ? OP_PUSH : (r < 72) ? OP_POP : (r < 86) ? OP_REMOVE : OP_PEEK;
      1:       func = (r < 10) ? OP_PUSH : (r < 45) ? OP_POP : (r < 85) ? OP_REMOVE : OP_PEEK;
      default: func = 2'($urandom_range(0, 3));
    endcase
    if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, 31);
    else pos = $urandom_range(1, $urandom_range(1, STACK_DEPTH + 1));
    return make_request(func, pos);
  endfunction

  // sender: one word in flight, a fresh gap set for every word (zero in every third run of 96 words)
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_stack_op(in_data));
        op_count[in_data.func]++;
        words_sent++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          in_data  <= pending_requests.pop_front();
          in_valid <= 1'b1;
          send_gap <= ((words_sent / 96) % 3 == 0) ? 0 : $urandom_range(0, 19);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: compare against the oldest prediction, then draw a stall
  always @(posedge clk) begin : receiver
    out_word_t want;
    logic      rdy_next;
    int        stall;
    if (rst_n) begin
      stall = recv_stall;
      if (out_valid && out_ready) begin
        words_seen++;
        status_count[out_data.status]++;
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: %h", out_data);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, out_data.status);
            error_count++;
          end
          if (out_data.out_id !== want.out_id) begin
            $error("out_id expected %h actual %h", want.out_id, out_data.out_id);
            error_count++;
          end
          if (out_data.out_tag !== want.out_tag) begin
            $error("out_tag expected %h actual %h", want.out_tag, out_data.out_tag);
            error_count++;
          end
          if (out_data.count_after !== want.count_after) begin
            $error("count_after expected %0d actual %0d", want.count_after,
                   out_data.count_after);
            error_count++;
          end
        end
        stall = ((words_seen / 80) % 4 == 1) ? 0 : $urandom_range(0, 19);
        // long hold-off so the block backs up into its input
        if (words_seen == 400 || words_seen == 1100) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy_next = 1'b0;
      end else if (stall > 0) begin
        stall--;
        rdy_next = 1'b0;
      end else begin
        rdy_next = 1'b1;
      end
      recv_stall = stall;
      out_ready <= rdy_next;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int bias;
    int n;
    // empty-stack errors
    pending_requests.push_back(make_request(OP_PEEK, 1));
    pending_requests.push_back(make_request(OP_POP, 1));
    pending_requests.push_back(make_request(OP_REMOVE, 0));
    pending_requests.push_back(make_request(OP_REMOVE, 1));
    // fill to the top, field extremes first, then one push past full
    pending_requests.push_back('{func: OP_PUSH, plane_id: 16'h0000, plane_tag: 64'h0,
                                 position: '1});
    pending_requests.push_back('{func: OP_PUSH, plane_id: 16'hFFFF, plane_tag: '1,
                                 position: '0});
    for (n = 2; n < STACK_DEPTH; n++) pending_requests.push_back(make_request(OP_PUSH, 0));
    pending_requests.push_back(make_request(OP_PUSH, 0));
    // bottom of a full stack, then out-of-range and zero positions, then top removal, peek and pop
    pending_requests.push_back(make_request(OP_REMOVE, STACK_DEPTH));
    pending_requests.push_back(make_request(OP_REMOVE, STACK_DEPTH));
    pending_requests.push_back(make_request(OP_REMOVE, 31));
    pending_requests.push_back(make_request(OP_REMOVE, 0));
    pending_requests.push_back(make_request(OP_REMOVE, 1));
    pending_requests.push_back(make_request(OP_PEEK, 0));
    pending_requests.push_back(make_request(OP_POP, 0));

    bias = 2;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 48 == 0) bias = $urandom_range(0, 2);
      pending_requests.push_back(make_random_request(bias));
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_requests.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (8) @(posedge clk);

    $display("covered %0d requests: push %0d, pop %0d, remove %0d, peek %0d; deepest %0d",
             words_sent, op_count[OP_PUSH], op_count[OP_POP], op_count[OP_REMOVE],
             op_count[OP_PEEK], deepest);
    $display("results %0d: ok %0d, empty %0d, full %0d, bad position %0d",
             words_seen, status_count[ST_OK], status_count[ST_EMPTY],
             status_count[ST_FULL], status_count[ST_BADPOS]);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
